/* hdl/tsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, constants and helpers for the two-rate sensor averager.
// ----------------------------------------------------------------------------
package tsa_pkg;

  // Channel order: cpu_temp, gpu_temp, cpu_load, gpu_load, ram percent
  localparam int NumChan = 5;
  localparam int ChanW   = $clog2(NumChan);
  localparam int AvgW    = 8;

  // Shared divider operand width
  localparam int DivW    = 32;
  localparam int DivCntW = $clog2(DivW);

  // Running sums
  localparam int SumW  = 24;
  localparam int HourW = 16;
  localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};
  localparam logic [HourW-1:0] HourMax = {HourW{1'b1}};

  // RAM percent numerator: 20-bit used times 100
  localparam int RamW    = 20;
  localparam int RamNumW = RamW + 7;
  localparam logic [6:0] RamScale = 7'd100;

  // Register reset values
  localparam logic [31:0] PeriodRst = 32'd60000;
  localparam logic [7:0]  MphRst    = 8'd60;

  // Register indexes (paddr bit 2)
  localparam logic RegPeriod = 1'b0;
  localparam logic RegMph    = 1'b1;

  // Item opcodes
  localparam logic OpSample = 1'b0;
  localparam logic OpTick   = 1'b1;

  // Result kinds
  localparam logic KindMinute = 1'b0;
  localparam logic KindHour   = 1'b1;

  typedef struct packed {
    logic [31:0] period_ms;
    logic [7:0]  mph;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                          kind;
    logic [NumChan-1:0][AvgW-1:0]  avg;
    logic                          last;
  } res_t;

  // Saturate a quotient to the average width
  function automatic logic [AvgW-1:0] clamp_avg(input logic [DivW-1:0] q);
    logic [AvgW-1:0] r;
    if (q > DivW'({AvgW{1'b1}})) r = {AvgW{1'b1}};
    else                         r = q[AvgW-1:0];
    return r;
  endfunction

endpackage

/* hdl/tsa_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_in_if
// Input channel: sample or tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsa_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  cpu_temp;
  logic [7:0]  gpu_temp;
  logic [7:0]  cpu_load;
  logic [7:0]  gpu_load;
  logic [19:0] ram_used;
  logic [19:0] ram_total;
  logic [31:0] now_ms;

  modport source (
    output valid, opcode, cpu_temp, gpu_temp, cpu_load, gpu_load,
           ram_used, ram_total, now_ms,
    input  ready
  );

  modport sink (
    input  valid, opcode, cpu_temp, gpu_temp, cpu_load, gpu_load,
           ram_used, ram_total, now_ms,
    output ready
  );
endinterface

/* hdl/tsa_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_out_if
// Result channel: minute or hour averages with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsa_out_if;
  logic       valid;
  logic       ready;
  logic       period_kind;
  logic [7:0] cpu_temp_avg;
  logic [7:0] gpu_temp_avg;
  logic [7:0] cpu_load_avg;
  logic [7:0] gpu_load_avg;
  logic [7:0] ram_pct_avg;
  logic       last_of_run;

  modport source (
    output valid, period_kind, cpu_temp_avg, gpu_temp_avg, cpu_load_avg,
           gpu_load_avg, ram_pct_avg, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, period_kind, cpu_temp_avg, gpu_temp_avg, cpu_load_avg,
           gpu_load_avg, ram_pct_avg, last_of_run,
    output ready
  );
endinterface

/* hdl/two_rate_sensor_averager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rate_sensor_averager
// Two-stage boxcar averager for sensor samples, minute and hour results.
// ----------------------------------------------------------------------------
// Samples are summed per channel; ticks commit minute averages once the
// configured period has elapsed and, every minutes_per_hour commits, hour
// averages too. All divisions run on one shared 32-step restoring divider
// under a small sequencer, and the input is not ready while an item is in
// work. A sample divides once for the RAM percent (not when RAM total is 0,
// and it is dropped when the count is saturated); a minute commit divides
// once per channel, and an hour rollover once more per channel. Results sit
// in a two-entry output buffer; a later commit waits only until that buffer
// has drained.
// ----------------------------------------------------------------------------
module two_rate_sensor_averager import tsa_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsa_in_if.sink      in_i,
  tsa_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RAM      = 4'd1;
  localparam logic [3:0] S_RAM_WAIT = 4'd2;
  localparam logic [3:0] S_ACC      = 4'd3;
  localparam logic [3:0] S_TICK     = 4'd4;
  localparam logic [3:0] S_MDIV     = 4'd5;
  localparam logic [3:0] S_MWAIT    = 4'd6;
  localparam logic [3:0] S_MFIN     = 4'd7;
  localparam logic [3:0] S_HDIV     = 4'd8;
  localparam logic [3:0] S_HWAIT    = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [3:0]             state_q, state_d;
  logic [ChanW-1:0]       ch_q, ch_d;
  logic [SumW-1:0]        msum_q [NumChan];
  logic [SumW-1:0]        msum_d [NumChan];
  logic [HourW-1:0]       hsum_q [NumChan];
  logic [HourW-1:0]       hsum_d [NumChan];
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [7:0]             mc_q, mc_d;
  logic [31:0]            last_q, last_d;
  logic                   hour_q, hour_d;

  // Latched item and partial results
  logic [NumChan-1:0][AvgW-1:0] samp_q, samp_d;
  logic [RamW-1:0]              used_q, used_d;
  logic [RamW-1:0]              total_q, total_d;
  logic [31:0]                  now_q, now_d;
  logic [NumChan-1:0][AvgW-1:0] mavg_q, mavg_d;
  logic [NumChan-1:0][AvgW-1:0] havg_q, havg_d;

  // Output buffer
  res_t       res_q [2];
  res_t       res_d [2];
  logic [1:0] ocnt_q, ocnt_d;
  logic       head_q, head_d;

  logic [RamNumW-1:0] ram_num;
  logic [31:0]        eff_last;
  logic [31:0]        elapsed;
  logic [7:0]         mc_next;
  logic [AvgW-1:0]    q_avg;
  logic [HourW:0]     hour_add;
  logic [SumW:0]      sum_add [NumChan];
  logic               out_pop;

  tsa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign out_pop    = out_o.valid && out_o.ready;

  assign ram_num  = RamNumW'(used_q) * RamNumW'(RamScale);
  assign eff_last = (last_q == '0) ? now_q : last_q;
  assign elapsed  = now_q - eff_last;
  assign mc_next  = mc_q + 8'd1;
  assign q_avg    = clamp_avg(div_rsp.quo);
  assign hour_add = {1'b0, hsum_q[ch_q]} + (HourW+1)'(q_avg);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum_add[c] = {1'b0, msum_q[c]} + (SumW+1)'(samp_q[c]);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    msum_d  = msum_q;
    hsum_d  = hsum_q;
    cnt_d   = cnt_q;
    mc_d    = mc_q;
    last_d  = last_q;
    hour_d  = hour_q;
    samp_d  = samp_q;
    used_d  = used_q;
    total_d = total_q;
    now_d   = now_q;
    mavg_d  = mavg_q;
    havg_d  = havg_q;
    res_d   = res_q;
    ocnt_d  = ocnt_q;
    head_d  = head_q;
    div_req = '{start: 1'b0, num: '0, den: '0};

    if (out_pop) begin
      ocnt_d = ocnt_q - 2'd1;
      head_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          samp_d[0] = in_i.cpu_temp;
          samp_d[1] = in_i.gpu_temp;
          samp_d[2] = in_i.cpu_load;
          samp_d[3] = in_i.gpu_load;
          used_d    = in_i.ram_used;
          total_d   = in_i.ram_total;
          now_d     = in_i.now_ms;
          if (in_i.opcode == OpTick)  state_d = S_TICK;
          else if (cnt_q == CountMax) state_d = S_IDLE;
          else                        state_d = S_RAM;
        end
      end
      S_RAM: begin
        if (total_q == '0) begin
          samp_d[NumChan-1] = '0;
          state_d = S_ACC;
        end else begin
          div_req = '{start: 1'b1, num: DivW'(ram_num), den: DivW'(total_q)};
          state_d = S_RAM_WAIT;
        end
      end
      S_RAM_WAIT: begin
        if (div_rsp.done) begin
          samp_d[NumChan-1] = q_avg;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        for (int c = 0; c < NumChan; c++) begin
          msum_d[c] = sum_add[c][SumW] ? SumMax : sum_add[c][SumW-1:0];
        end
        cnt_d   = cnt_q + 1'b1;
        state_d = S_IDLE;
      end
      S_TICK: begin
        if (elapsed < cfg.period_ms) begin
          last_d  = eff_last;
          state_d = S_IDLE;
        end else begin
          last_d  = now_q;
          ch_d    = '0;
          state_d = (cnt_q == '0) ? S_IDLE : S_MDIV;
        end
      end
      S_MDIV: begin
        div_req = '{start: 1'b1, num: DivW'(msum_q[ch_q]), den: DivW'(cnt_q)};
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (div_rsp.done) begin
          mavg_d[ch_q] = q_avg;
          msum_d[ch_q] = '0;
          hsum_d[ch_q] = hour_add[HourW] ? HourMax : hour_add[HourW-1:0];
          if (ch_q == ChanW'(NumChan - 1)) begin
            state_d = S_MFIN;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_MDIV;
          end
        end
      end
      S_MFIN: begin
        cnt_d = '0;
        mc_d  = mc_next;
        ch_d  = '0;
        if (mc_next >= cfg.mph && mc_next != '0) begin
          hour_d  = 1'b1;
          state_d = S_HDIV;
        end else begin
          hour_d  = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_HDIV: begin
        div_req = '{start: 1'b1, num: DivW'(hsum_q[ch_q]), den: DivW'(mc_q)};
        state_d = S_HWAIT;
      end
      S_HWAIT: begin
        if (div_rsp.done) begin
          havg_d[ch_q] = q_avg;
          hsum_d[ch_q] = '0;
          if (ch_q == ChanW'(NumChan - 1)) begin
            mc_d    = '0;
            state_d = S_EMIT;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_HDIV;
          end
        end
      end
      S_EMIT: begin
        // wait for the output buffer to drain, then load both slots
        if (ocnt_q == '0) begin
          res_d[0] = '{kind: KindMinute, avg: mavg_q, last: !hour_q};
          res_d[1] = '{kind: KindHour, avg: havg_q, last: 1'b1};
          ocnt_d   = hour_q ? 2'd2 : 2'd1;
          head_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      cnt_q   <= '0;
      mc_q    <= '0;
      last_q  <= '0;
      hour_q  <= 1'b0;
      ocnt_q  <= '0;
      head_q  <= 1'b0;
      for (int c = 0; c < NumChan; c++) begin
        msum_q[c] <= '0;
        hsum_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
      mc_q    <= mc_d;
      last_q  <= last_d;
      hour_q  <= hour_d;
      ocnt_q  <= ocnt_d;
      head_q  <= head_d;
      msum_q  <= msum_d;
      hsum_q  <= hsum_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    samp_q  <= samp_d;
    used_q  <= used_d;
    total_q <= total_d;
    now_q   <= now_d;
    mavg_q  <= mavg_d;
    havg_q  <= havg_d;
    res_q   <= res_d;
  end

  // Result channel
  assign out_o.valid        = (ocnt_q != '0);
  assign out_o.period_kind  = res_q[head_q].kind;
  assign out_o.cpu_temp_avg = res_q[head_q].avg[0];
  assign out_o.gpu_temp_avg = res_q[head_q].avg[1];
  assign out_o.cpu_load_avg = res_q[head_q].avg[2];
  assign out_o.gpu_load_avg = res_q[head_q].avg[3];
  assign out_o.ram_pct_avg  = res_q[head_q].avg[4];
  assign out_o.last_of_run  = res_q[head_q].last;

  // Sample count only steps by one or clears on a commit
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q == '0))
    else $error("sample count jumped");

  // Divider results arrive only while the sequencer waits for one
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |->
      (state_q == S_RAM_WAIT) || (state_q == S_MWAIT) || (state_q == S_HWAIT))
    else $error("unexpected divider result");

  // A minute result without the last flag always has its hour result behind it
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_of_run) |-> (ocnt_q == 2'd2) && !head_q)
    else $error("minute result lost its hour result");

  // Nothing is started on the divider outside the issue states
  a_div_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (state_q == S_RAM_WAIT) || (state_q == S_MWAIT) ||
                      (state_q == S_HWAIT))
    else $error("divider start outside issue state");

endmodule

/* hdl/tsa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsa_div import tsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    num_q, num_d;   // dividend shifts out, quotient shifts in
  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    den_q, den_d;
  logic [DivW:0]      rem_sh;
  logic               fits;

  assign rem_sh = {rem_q, num_q[DivW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // Iteration step
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DivW'(rem_sh - {1'b0, den_q}) : rem_sh[DivW-1:0];
      num_d = {num_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

/* hdl/tsa_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_regs
// APB-style configuration registers: minute period and minutes per hour.
// ----------------------------------------------------------------------------
module tsa_regs import tsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ms <= PeriodRst;
      cfg_q.mph       <= MphRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegPeriod: cfg_q.period_ms <= pwdata;
        RegMph:    cfg_q.mph       <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr[2])
      RegPeriod: prdata = cfg_q.period_ms;
      RegMph:    prdata = {24'd0, cfg_q.mph};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-rate sensor averager. A queue-fed driver
// sends sample and tick items with random gaps. The bench keeps its own
// model of the minute and hour sums, and every item it hands over updates
// that model. A monitor that stalls at random compares each average result
// with the oldest one that the model has predicted. The registers are
// rewritten between phases: the reset period with two minutes per hour, a
// period of zero, the full 32-bit period, 255 minutes per hour, a
// one-millisecond period with short hours, and random settings.
// ----------------------------------------------------------------------------
module testbench import tsa_pkg::*; ();

  localparam int          ClkPeriod    = 10;
  localparam int          ResetCycles  = 8;
  localparam int          CountW       = 16;
  localparam int          SettleCycles = 400;   // longer than an hour commit
  localparam int          DrainLimit   = 4000;
  localparam int          MaxReports   = 20;
  localparam longint      TimeoutNs    = 50_000_000;
  localparam logic [2:0]  AddrPeriod   = {RegPeriod, 2'b00};
  localparam logic [2:0]  AddrMph      = {RegMph, 2'b00};
  localparam logic [31:0] DirBase      = 32'hFFFF_0000;

  typedef struct packed {
    logic        op;
    logic [7:0]  cpu_temp;
    logic [7:0]  gpu_temp;
    logic [7:0]  cpu_load;
    logic [7:0]  gpu_load;
    logic [19:0] ram_used;
    logic [19:0] ram_total;
    logic [31:0] now_ms;
    logic [3:0]  gap;
  } sensor_item_t;

  typedef struct packed {
    logic                         kind;
    logic [NumChan-1:0][AvgW-1:0] avg;
    logic                         last;
  } avg_result_t;

  // Clock, reset and register port
  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Channel drive
  logic         in_valid  = 1'b0;
  sensor_item_t in_item   = '0;
  logic         out_ready = 1'b0;

  // Stimulus bookkeeping
  sensor_item_t item_queue [$];
  int           items_queued = 0;
  int           items_taken  = 0;
  int           idle_wait    = 0;
  bit           src_calm     = 1'b0;
  logic [31:0]  gen_last     = '0;    // tick time tracking, mirrors the block
  logic [31:0]  gen_now      = '0;

  // Model of the averager
  logic [31:0]       cfg_period   = PeriodRst;
  logic [7:0]        cfg_mph      = MphRst;
  logic [SumW-1:0]   minute_sum [NumChan] = '{default: '0};
  logic [CountW-1:0] samples_held = '0;
  logic [HourW-1:0]  hour_sum [NumChan]   = '{default: '0};
  logic [7:0]        minutes_held = '0;
  logic [31:0]       last_commit  = '0;
  avg_result_t       expected_avgs [$];

  // Result checking
  avg_result_t got;
  avg_result_t want;
  int          stall_wait     = 0;
  int          hold;
  bit          sink_calm      = 1'b0;
  int          results_seen   = 0;
  int          minute_results = 0;
  int          hour_results   = 0;
  int          error_count    = 0;
  int          n_samples      = 0;
  int          n_ticks        = 0;
  int          n_dropped      = 0;
  string       chan_name [NumChan] = '{"cpu_temp", "gpu_temp", "cpu_load", "gpu_load",
                                       "ram_pct"};

  tsa_in_if  sensor_in ();
  tsa_out_if avg_out ();

  assign sensor_in.valid     = in_valid;
  assign sensor_in.opcode    = in_item.op;
  assign sensor_in.cpu_temp  = in_item.cpu_temp;
  assign sensor_in.gpu_temp  = in_item.gpu_temp;
  assign sensor_in.cpu_load  = in_item.cpu_load;
  assign sensor_in.gpu_load  = in_item.gpu_load;
  assign sensor_in.ram_used  = in_item.ram_used;
  assign sensor_in.ram_total = in_item.ram_total;
  assign sensor_in.now_ms    = in_item.now_ms;
  assign avg_out.ready       = out_ready;

  two_rate_sensor_averager #(.COUNT_WIDTH(CountW)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (sensor_in),
    .out_o   (avg_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("%0t ns  ERROR: %s", $time, msg);
  endtask

  function automatic logic [7:0] to_avg8(input int unsigned v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // Fold one accepted item into the model; push the averages it produces
  function automatic void fold_item(input sensor_item_t it);
    int unsigned vals [NumChan];
    logic [7:0]  m_avg [NumChan];
    logic [7:0]  h_avg [NumChan];
    int unsigned acc;
    logic [31:0] elapsed;
    logic        hour_done;
    avg_result_t r;
    if (it.op == OpSample) begin
      n_samples++;
      if (samples_held == {CountW{1'b1}}) begin
        n_dropped++;
        return;
      end
      vals[0] = it.cpu_temp;
      vals[1] = it.gpu_temp;
      vals[2] = it.cpu_load;
      vals[3] = it.gpu_load;
      vals[4] = (it.ram_total == '0) ? 0 :
                to_avg8((32'(it.ram_used) * 100) / 32'(it.ram_total));
      for (int c = 0; c < NumChan; c++) begin
        acc = 32'(minute_sum[c]) + vals[c];
        minute_sum[c] = (acc > SumMax) ? SumMax : SumW'(acc);
      end
      samples_held = samples_held + 1'b1;
      return;
    end

    // Tick: an unset time loads first, then the elapsed check
    n_ticks++;
    if (last_commit == '0) last_commit = it.now_ms;
    elapsed = it.now_ms - last_commit;
    if (elapsed < cfg_period) return;
    last_commit = it.now_ms;
    if (samples_held == '0) return;

    for (int c = 0; c < NumChan; c++) begin
      m_avg[c] = to_avg8(32'(minute_sum[c]) / 32'(samples_held));
      minute_sum[c] = '0;
      acc = 32'(hour_sum[c]) + m_avg[c];
      hour_sum[c] = (acc > HourMax) ? HourMax : HourW'(acc);
    end
    samples_held = '0;
    minutes_held = minutes_held + 8'd1;

    hour_done = (minutes_held >= cfg_mph) && (minutes_held != '0);
    if (hour_done) begin
      for (int c = 0; c < NumChan; c++) begin
        h_avg[c] = to_avg8(32'(hour_sum[c]) / 32'(minutes_held));
        hour_sum[c] = '0;
      end
      minutes_held = '0;
    end

    // Minute result first, hour result second
    r.kind = KindMinute;
    for (int c = 0; c < NumChan; c++) r.avg[c] = m_avg[c];
    r.last = !hour_done;
    expected_avgs.push_back(r);
    if (hour_done) begin
      r.kind = KindHour;
      for (int c = 0; c < NumChan; c++) r.avg[c] = h_avg[c];
      r.last = 1'b1;
      expected_avgs.push_back(r);
    end
  endfunction

  // Item driver: each queued item goes out after its own idle gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      idle_wait <= 0;
    end else if (in_valid && sensor_in.ready) begin
      fold_item(in_item);
      items_taken++;
      idle_wait <= 0;
      if (item_queue.size() > 0 && item_queue[0].gap == '0) begin
        in_item <= item_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && item_queue.size() > 0) begin
      if (idle_wait >= item_queue[0].gap) begin
        in_item   <= item_queue.pop_front();
        in_valid  <= 1'b1;
        idle_wait <= 0;
      end else begin
        idle_wait <= idle_wait + 1;
      end
    end
  end

  // Result monitor: compare with the oldest prediction, then stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_wait <= 0;
    end else if (out_ready && avg_out.valid) begin
      got.kind   = avg_out.period_kind;
      got.avg[0] = avg_out.cpu_temp_avg;
      got.avg[1] = avg_out.gpu_temp_avg;
      got.avg[2] = avg_out.cpu_load_avg;
      got.avg[3] = avg_out.gpu_load_avg;
      got.avg[4] = avg_out.ram_pct_avg;
      got.last   = avg_out.last_of_run;
      results_seen++;
      if (expected_avgs.size() == 0) begin
        report_error($sformatf("result %0d arrived with none expected (kind %0d)",
                               results_seen, got.kind));
      end else begin
        want = expected_avgs.pop_front();
        if (got.kind !== want.kind)
          report_error($sformatf("result %0d period_kind: got %0d, expected %0d",
                                 results_seen, got.kind, want.kind));
        for (int c = 0; c < NumChan; c++) begin
          if (got.avg[c] !== want.avg[c])
            report_error($sformatf("result %0d %s avg: got %0d, expected %0d",
                                   results_seen, chan_name[c], got.avg[c], want.avg[c]));
        end
        if (got.last !== want.last)
          report_error($sformatf("result %0d last_of_run: got %0d, expected %0d",
                                 results_seen, got.last, want.last));
        if (want.kind == KindHour) hour_results++;
        else minute_results++;
      end
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      hold = sink_calm ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_ready  <= 1'b0;
        stall_wait <= hold - 1;
      end
    end else if (!out_ready) begin
      if (stall_wait == 0) out_ready <= 1'b1;
      else stall_wait <= stall_wait - 1;
    end
  end

  // One register access: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_config();
    logic [31:0] rd;
    apb_access(1'b0, AddrPeriod, '0, rd);
    if (rd !== cfg_period)
      report_error($sformatf("minute_period_ms reads %0d, expected %0d", rd, cfg_period));
    apb_access(1'b0, AddrMph, '0, rd);
    if (rd[7:0] !== cfg_mph)
      report_error($sformatf("minutes_per_hour reads %0d, expected %0d", rd[7:0], cfg_mph));
  endtask

  task automatic load_config(input logic [31:0] period, input logic [7:0] mph);
    logic [31:0] rd;
    apb_access(1'b1, AddrPeriod, period, rd);
    apb_access(1'b1, AddrMph, {24'd0, mph}, rd);
    cfg_period = period;
    cfg_mph    = mph;
    check_config();
  endtask

  function automatic void push_item(input sensor_item_t it, input bit fast);
    it.gap = (fast || src_calm) ? '0 : 4'($urandom_range(0, 7));
    if ($urandom_range(0, 23) == 0) src_calm = !src_calm;
    item_queue.push_back(it);
    items_queued++;
  endfunction

  // Sample: time field carries noise, it is ignored
  function automatic void push_sample(input logic [7:0] ct, input logic [7:0] gt,
                                      input logic [7:0] cl, input logic [7:0] gl,
                                      input logic [19:0] used, input logic [19:0] total,
                                      input bit fast);
    sensor_item_t it;
    it           = '0;
    it.op        = OpSample;
    it.cpu_temp  = ct;
    it.gpu_temp  = gt;
    it.cpu_load  = cl;
    it.gpu_load  = gl;
    it.ram_used  = used;
    it.ram_total = total;
    it.now_ms    = $urandom;
    push_item(it, fast);
  endfunction

  // Tick: sensor fields carry noise; track the commit time as the block does
  function automatic void push_tick(input logic [31:0] now);
    sensor_item_t it;
    it           = '0;
    it.op        = OpTick;
    it.cpu_temp  = 8'($urandom);
    it.gpu_temp  = 8'($urandom);
    it.cpu_load  = 8'($urandom);
    it.gpu_load  = 8'($urandom);
    it.ram_used  = 20'($urandom);
    it.ram_total = 20'($urandom);
    it.now_ms    = now;
    push_item(it, 1'b0);
    if (gen_last == '0) gen_last = now;
    if (now - gen_last >= cfg_period) gen_last = now;
    gen_now = now;
  endfunction

  function automatic void push_random_sample();
    logic [19:0] total;
    logic [19:0] used;
    case ($urandom_range(0, 7))
      0:       total = '0;
      1:       total = 20'hFFFFF;
      2:       total = 20'($urandom_range(1, 15));
      default: total = 20'($urandom_range(1, 20'hFFFFF));
    endcase
    // mostly used <= total, sometimes anything (percent above 100)
    used = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, total));
    push_sample(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), used, total, 1'b0);
  endfunction

  // Minutes: a few samples, then a tick mostly past the period, with noise
  function automatic void push_random_minutes(input int n_items, input int max_samples);
    int          start;
    logic [31:0] now;
    start = items_queued;
    while (items_queued - start < n_items) begin
      repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_samples))
        push_random_sample();
      case ($urandom_range(0, 9))
        0:       now = $urandom;
        1:       now = gen_last + cfg_period - 32'd1;
        2:       now = gen_now;
        3:       now = gen_last + cfg_period;
        default: now = gen_last + cfg_period + 32'($urandom_range(0, 50));
      endcase
      push_tick(now);
    end
  endfunction

  // Wait until every item is taken and every result seen, then let it settle
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    while (items_taken != items_queued) @(posedge clk_i);
    while (expected_avgs.size() > 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_avgs.size() > 0) begin
      report_error($sformatf("%0d expected results never arrived", expected_avgs.size()));
      expected_avgs.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Phases
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_config();

    // Directed: field extremes, RAM percent corners, unset time, wrap, rollover
    load_config(PeriodRst, 8'd2);
    push_tick(32'd0);
    push_tick(DirBase);
    push_sample(8'h00, 8'h00, 8'h00, 8'h00, 20'h00000, 20'h00000, 1'b0);
    push_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF, 20'hFFFFF, 20'hFFFFF, 1'b0);
    push_sample(8'hFF, 8'h00, 8'hFF, 8'h00, 20'hFFFFF, 20'h00001, 1'b0);
    push_sample(8'h00, 8'hFF, 8'h00, 8'hFF, 20'h00001, 20'hFFFFF, 1'b0);
    push_sample(8'h80, 8'h7F, 8'h01, 8'hFE, 20'hFFFFF, 20'h00000, 1'b0);
    push_sample(8'hAA, 8'h55, 8'hAA, 8'h55, 20'h55555, 20'hAAAAA, 1'b0);
    push_sample(8'h55, 8'hAA, 8'h55, 8'hAA, 20'hAAAAA, 20'hFFFFF, 1'b0);
    push_tick(DirBase + 32'd59999);
    push_tick(DirBase + 32'd60000);                // exactly one period, commits
    push_tick(DirBase + 32'd120000);               // wraps past zero, nothing summed
    push_sample(8'd200, 8'd100, 8'd50, 8'd25, 20'd3, 20'd7, 1'b0);
    push_sample(8'd201, 8'd101, 8'd51, 8'd26, 20'd700, 20'd7, 1'b0);
    push_tick(DirBase + 32'd180000);               // minute and hour
    push_tick(DirBase + 32'd240000);
    drain_and_settle();

    // Period zero elapses on every tick; zero minutes per hour acts as one
    load_config(32'd0, 8'd0);
    push_random_minutes(60, 3);
    drain_and_settle();

    // Longest period: only a tick one before the last commit elapses
    load_config(32'hFFFF_FFFF, 8'd1);
    push_random_minutes(60, 3);
    drain_and_settle();

    // Longest hour: 255 minutes of one sample each
    load_config(32'd7, 8'd255);
    repeat (270) begin
      push_random_sample();
      push_tick(gen_last + cfg_period + 32'($urandom_range(0, 3)));
    end
    drain_and_settle();

    // One-millisecond period with short hours
    load_config(32'd1, 8'd3);
    repeat (3) push_random_sample();
    push_tick(gen_now + 32'd1);
    push_tick(gen_now + 32'd2);
    push_random_minutes(30, 3);
    drain_and_settle();

    // Random settings
    repeat (2) begin
      load_config(32'($urandom_range(1, 5000)), 8'($urandom_range(2, 6)));
      push_random_minutes(120, 4);
      drain_and_settle();
    end

    $display("Run covered %0d items: %0d samples (%0d dropped at full count), %0d ticks.",
             items_taken, n_samples, n_dropped, n_ticks);
    $display("Checked %0d minute and %0d hour results, %0d errors.",
             minute_results, hour_results, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("Timed out with %0d of %0d items taken, %0d results pending.",
             items_taken, items_queued, expected_avgs.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
